/* src/gjk_pkg.sv */
// shared widths, codes and operation types for the gjk simplex block
package gjk_pkg;

  localparam int PT_W   = 16;  // port width of one coordinate
  localparam int DIR_W  = 56;  // direction component and scratch vector width
  localparam int SH_W   = 18;  // short operand of the multiplier (edge vectors)
  localparam int ACC_W  = 74;  // product and accumulator width
  localparam int KIND_W = 2;
  localparam int ITER_W = 7;
  localparam int SIZE_W = 3;

  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd2;

  localparam logic [ITER_W-1:0] ITER_RESET = 7'd64;

  localparam logic [1:0] FLAG_NONE     = 2'd0;
  localparam logic [1:0] FLAG_ENCLOSED = 2'd1;
  localparam logic [1:0] FLAG_GAVE_UP  = 2'd2;

  typedef logic signed [DIR_W-1:0] dir_t;

  // scratch vector slots; the first four only ever hold short edge vectors
  typedef enum logic [2:0] {
    VR_AB, VR_AC, VR_AD, VR_AO, VR_N, VR_T, VR_W
  } vreg_t;

  // one vector operation of the shared multiply-accumulate unit
  typedef struct packed {
    logic  is_dot;
    vreg_t dst;
    vreg_t lng;
    vreg_t sht;
    logic  flip;
  } vop_t;

endpackage

/* src/gjk_if.sv */
// handshake channels of the gjk simplex block: input points, results, configuration
interface gjk_in_if import gjk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PT_W-1:0]   point_x;
  logic [PT_W-1:0]   point_y;
  logic [PT_W-1:0]   point_z;
  modport source (output valid, kind, point_x, point_y, point_z, input ready);
  modport sink   (input valid, kind, point_x, point_y, point_z, output ready);
endinterface

interface gjk_out_if import gjk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIR_W-1:0]  dir_x;
  logic [DIR_W-1:0]  dir_y;
  logic [DIR_W-1:0]  dir_z;
  logic              enclosed;
  logic              gave_up;
  logic [SIZE_W-1:0] simplex_size;
  modport source (output valid, dir_x, dir_y, dir_z, enclosed, gave_up, simplex_size,
                  input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, enclosed, gave_up, simplex_size,
                  output ready);
endinterface

interface gjk_cfg_if import gjk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ITER_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/gjk_simplex_reduction_top.sv */
// gjk simplex update in 3d: sequencer around one shared multiply-accumulate unit
//
// usage
//   in_ch  : one support point per item; kind 0 starts a simplex, kind 1 forms the
//            line, kind 2 adds a point and runs the triangle or tetrahedron step
//   out_ch : exactly one result item per input item, in order: next search
//            direction (unnormalised), enclosed, gave_up and the simplex size
//   cfg_ch : writes max_iterations (reset 64); always ready, write only when idle
// operation
//   one item at a time; every multiply-accumulate goes through operand read,
//   multiply and accumulate on the single 56x18 multiplier, so the time an item
//   takes is set by the number of products that its step needs
// reset
//   synchronous, active low: vertices zero, size one, counters and flags clear
// stalls
//   the result sits in an output register; a new item is taken while it waits,
//   and the next result holds in the sequencer until the register frees up
module gjk_simplex_reduction_top import gjk_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  gjk_in_if.sink       in_ch,
  gjk_out_if.source    out_ch,
  gjk_cfg_if.sink      cfg_ch
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_RD, ST_MUL, ST_ACC, ST_DECIDE, ST_OUT
  } state_t;

  // algorithm steps, each one vector operation on the shared unit
  typedef enum logic [4:0] {
    SP_K1_T, SP_K1_DIR,
    SP_TR_N, SP_TR_T1, SP_TR_D1, SP_TR_M1, SP_TR_W1,
    SP_TR_T2, SP_TR_D2, SP_TR_M2, SP_TR_W2, SP_TR_D3,
    SP_TE_N1, SP_TE_D1, SP_TE_N2, SP_TE_D2, SP_TE_N3, SP_TE_D3
  } step_t;

  state_t                  state_r;
  step_t                   step_r;
  logic [KIND_W-1:0]       kind_r;
  logic signed [COORD_BITS-1:0] p_r  [3];
  logic signed [COORD_BITS-1:0] vb_r [3];
  logic signed [COORD_BITS-1:0] vc_r [3];
  logic signed [COORD_BITS-1:0] vd_r [3];
  logic [SIZE_W-1:0]       dim_r;
  logic [ITER_W-1:0]       step_cnt_r;
  logic [1:0]              flags_r;
  logic [ITER_W-1:0]       max_iter_r;

  dir_t                    vr_r [7][3];   // scratch vector file
  logic [1:0]              comp_r;
  logic                    term_r;
  logic signed [DIR_W-1:0] opa_r;
  logic signed [SH_W-1:0]  opb_r;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  logic                    out_valid_r;
  dir_t                    out_dir_r [3];
  logic [1:0]              out_flags_r;
  logic [SIZE_W-1:0]       out_size_r;

  vop_t                    op;
  logic [1:0]              comp_j;
  logic [1:0]              comp_k;
  logic [1:0]              ai;
  logic [1:0]              bi;
  logic                    neg;
  logic                    first;
  logic                    pos;
  logic [1:0]              fin_flags;
  logic                    out_load;

  function automatic dir_t ext_c(input logic signed [COORD_BITS-1:0] v);
    return dir_t'(v);
  endfunction

  // operation of the current step
  always_comb begin
    op = '0;
    unique case (step_r)
      SP_K1_T:   op = '{1'b0, VR_T, VR_AB, VR_AO, 1'b0};  // u x (-b)
      SP_K1_DIR: op = '{1'b0, VR_W, VR_T,  VR_AB, 1'b0};  // (u x -b) x u
      SP_TR_N:   op = '{1'b0, VR_N, VR_AB, VR_AC, 1'b0};  // n = ab x ac
      SP_TR_T1:  op = '{1'b0, VR_T, VR_N,  VR_AB, 1'b1};  // ab x n
      SP_TR_D1:  op = '{1'b1, VR_T, VR_T,  VR_AO, 1'b0};
      SP_TR_M1:  op = '{1'b0, VR_T, VR_AB, VR_AO, 1'b0};
      SP_TR_W1:  op = '{1'b0, VR_W, VR_T,  VR_AB, 1'b0};
      SP_TR_T2:  op = '{1'b0, VR_T, VR_N,  VR_AC, 1'b0};  // n x ac
      SP_TR_D2:  op = '{1'b1, VR_T, VR_T,  VR_AO, 1'b0};
      SP_TR_M2:  op = '{1'b0, VR_T, VR_AC, VR_AO, 1'b0};
      SP_TR_W2:  op = '{1'b0, VR_W, VR_T,  VR_AC, 1'b0};
      SP_TR_D3:  op = '{1'b1, VR_N, VR_N,  VR_AO, 1'b0};
      SP_TE_N1:  op = '{1'b0, VR_N, VR_AB, VR_AC, 1'b0};
      SP_TE_D1:  op = '{1'b1, VR_N, VR_N,  VR_AO, 1'b0};
      SP_TE_N2:  op = '{1'b0, VR_N, VR_AC, VR_AD, 1'b0};
      SP_TE_D2:  op = '{1'b1, VR_N, VR_N,  VR_AO, 1'b0};
      SP_TE_N3:  op = '{1'b0, VR_N, VR_AD, VR_AB, 1'b0};
      SP_TE_D3:  op = '{1'b1, VR_N, VR_N,  VR_AO, 1'b0};
      default:   op = '0;
    endcase
  end

  always_comb begin
    comp_j = (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
    comp_k = (comp_r == 2'd0) ? 2'd2 : comp_r - 2'd1;
    if (op.is_dot) begin
      ai = comp_r;
      bi = comp_r;
    end else if (!term_r) begin
      ai = comp_j;
      bi = comp_k;
    end else begin
      ai = comp_k;
      bi = comp_j;
    end
    neg     = !op.is_dot && (term_r ^ op.flip);
    first   = op.is_dot ? (comp_r == 2'd0) : !term_r;
    acc_nxt = neg ? ((first ? '0 : acc_r) - prod_r) : ((first ? '0 : acc_r) + prod_r);
    pos     = !acc_r[ACC_W-1] && (acc_r != '0);
    // flags once a point addition finishes without enclosure
    fin_flags = (step_cnt_r >= max_iter_r) ? FLAG_GAVE_UP : FLAG_NONE;
    // result register takes a new item when empty or being drained
    out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.dir_x        = out_dir_r[0];
  assign out_ch.dir_y        = out_dir_r[1];
  assign out_ch.dir_z        = out_dir_r[2];
  assign out_ch.enclosed     = out_flags_r[0];
  assign out_ch.gave_up      = out_flags_r[1];
  assign out_ch.simplex_size = out_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_K1_T;
      dim_r       <= 3'd1;
      step_cnt_r  <= '0;
      flags_r     <= FLAG_NONE;
      max_iter_r  <= ITER_RESET;
      out_valid_r <= 1'b0;
      comp_r      <= 2'd0;
      term_r      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        vb_r[i] <= '0;
        vc_r[i] <= '0;
        vd_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        max_iter_r <= cfg_ch.data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            kind_r  <= in_ch.kind;
            p_r[0]  <= in_ch.point_x[COORD_BITS-1:0];
            p_r[1]  <= in_ch.point_y[COORD_BITS-1:0];
            p_r[2]  <= in_ch.point_z[COORD_BITS-1:0];
            state_r <= ST_SETUP;
          end
        end

        ST_SETUP: begin
          comp_r <= 2'd0;
          term_r <= 1'b0;
          priority if (kind_r == KIND_FIRST) begin
            vc_r       <= p_r;
            dim_r      <= 3'd1;
            step_cnt_r <= '0;
            flags_r    <= FLAG_NONE;
            for (int i = 0; i < 3; i++) vr_r[VR_W][i] <= -ext_c(p_r[i]);
            state_r    <= ST_OUT;
          end else if (kind_r == KIND_SECOND) begin
            vb_r       <= p_r;
            dim_r      <= 3'd2;
            step_cnt_r <= '0;
            flags_r    <= FLAG_NONE;
            for (int i = 0; i < 3; i++) begin
              vr_r[VR_AB][i] <= ext_c(vc_r[i]) - ext_c(p_r[i]);
              vr_r[VR_AO][i] <= -ext_c(p_r[i]);
            end
            step_r  <= SP_K1_T;
            state_r <= ST_RD;
          end else if (kind_r == KIND_ADD && flags_r == FLAG_NONE && dim_r >= 3'd2) begin
            step_cnt_r <= step_cnt_r + 7'd1;
            for (int i = 0; i < 3; i++) begin
              vr_r[VR_AB][i] <= ext_c(vb_r[i]) - ext_c(p_r[i]);
              vr_r[VR_AC][i] <= ext_c(vc_r[i]) - ext_c(p_r[i]);
              vr_r[VR_AD][i] <= ext_c(vd_r[i]) - ext_c(p_r[i]);
              vr_r[VR_AO][i] <= -ext_c(p_r[i]);
            end
            step_r  <= (dim_r == 3'd2) ? SP_TR_N : SP_TE_N1;
            state_r <= ST_RD;
          end else begin
            // ignored item: zero direction, flags and size repeated
            for (int i = 0; i < 3; i++) vr_r[VR_W][i] <= '0;
            state_r <= ST_OUT;
          end
        end

        ST_RD: begin
          opa_r   <= vr_r[op.lng][ai];
          opb_r   <= vr_r[op.sht][bi][SH_W-1:0];
          state_r <= ST_MUL;
        end

        ST_MUL: begin
          prod_r  <= opa_r * opb_r;
          state_r <= ST_ACC;
        end

        ST_ACC: begin
          acc_r <= acc_nxt;
          if (!op.is_dot && term_r) begin
            vr_r[op.dst][comp_r] <= acc_nxt[DIR_W-1:0];
          end
          if (!op.is_dot && !term_r) begin
            term_r  <= 1'b1;
            state_r <= ST_RD;
          end else begin
            term_r <= 1'b0;
            if (comp_r == 2'd2) begin
              comp_r  <= 2'd0;
              state_r <= ST_DECIDE;
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= ST_RD;
            end
          end
        end

        ST_DECIDE: begin
          state_r <= ST_RD;
          unique case (step_r)
            SP_K1_T: step_r <= SP_K1_DIR;
            SP_K1_DIR: begin
              // perpendicular vanished: fall back to crossings with the x then y axis
              if (vr_r[VR_W][0] == '0 && vr_r[VR_W][1] == '0 && vr_r[VR_W][2] == '0) begin
                if (vr_r[VR_AB][1] != '0 || vr_r[VR_AB][2] != '0) begin
                  vr_r[VR_W][0] <= '0;
                  vr_r[VR_W][1] <= vr_r[VR_AB][2];
                  vr_r[VR_W][2] <= -vr_r[VR_AB][1];
                end else begin
                  vr_r[VR_W][0] <= -vr_r[VR_AB][2];
                  vr_r[VR_W][1] <= '0;
                  vr_r[VR_W][2] <= vr_r[VR_AB][0];
                end
              end
              state_r <= ST_OUT;
            end
            SP_TR_N:  step_r <= SP_TR_T1;
            SP_TR_T1: step_r <= SP_TR_D1;
            SP_TR_D1: step_r <= pos ? SP_TR_M1 : SP_TR_T2;
            SP_TR_M1: step_r <= SP_TR_W1;
            SP_TR_W1: begin
              // keep edge ab
              vc_r    <= p_r;
              dim_r   <= 3'd2;
              flags_r <= fin_flags;
              state_r <= ST_OUT;
            end
            SP_TR_T2: step_r <= SP_TR_D2;
            SP_TR_D2: step_r <= pos ? SP_TR_M2 : SP_TR_D3;
            SP_TR_M2: step_r <= SP_TR_W2;
            SP_TR_W2: begin
              // keep edge ac
              vb_r    <= p_r;
              dim_r   <= 3'd2;
              flags_r <= fin_flags;
              state_r <= ST_OUT;
            end
            SP_TR_D3: begin
              if (pos) begin
                vd_r <= vc_r;
                vc_r <= vb_r;
                for (int i = 0; i < 3; i++) vr_r[VR_W][i] <= vr_r[VR_N][i];
              end else begin
                vd_r <= vb_r;
                for (int i = 0; i < 3; i++) vr_r[VR_W][i] <= -vr_r[VR_N][i];
              end
              vb_r    <= p_r;
              dim_r   <= 3'd3;
              flags_r <= fin_flags;
              state_r <= ST_OUT;
            end
            SP_TE_N1: step_r <= SP_TE_D1;
            SP_TE_D1: begin
              if (pos) begin
                vd_r    <= vc_r;
                vc_r    <= vb_r;
                vb_r    <= p_r;
                dim_r   <= 3'd3;
                flags_r <= fin_flags;
                for (int i = 0; i < 3; i++) vr_r[VR_W][i] <= vr_r[VR_N][i];
                state_r <= ST_OUT;
              end else begin
                step_r <= SP_TE_N2;
              end
            end
            SP_TE_N2: step_r <= SP_TE_D2;
            SP_TE_D2: begin
              if (pos) begin
                vb_r    <= p_r;
                dim_r   <= 3'd3;
                flags_r <= fin_flags;
                for (int i = 0; i < 3; i++) vr_r[VR_W][i] <= vr_r[VR_N][i];
                state_r <= ST_OUT;
              end else begin
                step_r <= SP_TE_N3;
              end
            end
            SP_TE_N3: step_r <= SP_TE_D3;
            SP_TE_D3: begin
              if (pos) begin
                vc_r    <= vd_r;
                vd_r    <= vb_r;
                vb_r    <= p_r;
                dim_r   <= 3'd3;
                flags_r <= fin_flags;
                for (int i = 0; i < 3; i++) vr_r[VR_W][i] <= vr_r[VR_N][i];
              end else begin
                // origin inside the tetrahedron
                dim_r   <= 3'd4;
                flags_r <= FLAG_ENCLOSED;
                for (int i = 0; i < 3; i++) vr_r[VR_W][i] <= '0;
              end
              state_r <= ST_OUT;
            end
            default: state_r <= ST_OUT;
          endcase
        end

        ST_OUT: begin
          if (out_load) begin
            out_dir_r   <= vr_r[VR_W];
            out_flags_r <= flags_r;
            out_size_r  <= dim_r;
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
